FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the dirty block region tracker.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define DBRT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DBRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/core/dbrt_pkg.sv
// Package of the dirty block region tracker: grid sizes, widths, codes, helpers.
// Used by dirty_block_region_tracker and its testbench; depends on nothing.
`default_nettype none

package dbrt_pkg;

	localparam int MAX_BLOCK_COLS = 64;
	localparam int MAX_BLOCK_ROWS = 64;
	localparam int BLK_W_LG       = 4;
	localparam int BLK_H_LG       = 4;
	localparam int BLOCK_WIDTH    = 1 << BLK_W_LG;
	localparam int BLOCK_HEIGHT   = 1 << BLK_H_LG;

	localparam int COL_CNT_W = $clog2(MAX_BLOCK_COLS + 1);
	localparam int ROW_CNT_W = $clog2(MAX_BLOCK_ROWS + 1);
	localparam int COL_IDX_W = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
	localparam int ROW_W     = MAX_BLOCK_ROWS;
	localparam int EDGE_W    = 11;
	localparam int COORD_W   = 16;

	typedef logic [ROW_W-1:0]     col_word_t;
	typedef logic [COL_CNT_W-1:0] col_cnt_t;
	typedef logic [ROW_CNT_W-1:0] row_cnt_t;
	typedef logic [EDGE_W-1:0]    edge_t;

	typedef enum logic [1:0] {
		REQ_MARK    = 2'd0,
		REQ_CLEAR   = 2'd1,
		REQ_FILL    = 2'd2,
		REQ_EXTRACT = 2'd3
	} req_t;

	typedef enum logic [0:0] {
		REG_VIEW_WIDTH  = 1'b0,
		REG_VIEW_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MRD,
		ST_MWR,
		ST_FILL,
		ST_XRD,
		ST_XT,
		ST_XSEG,
		ST_XB,
		ST_RRD,
		ST_RCHK,
		ST_RESP
	} state_t;

	// Bits 0 .. n-1 set.
	function automatic col_word_t low_mask(input row_cnt_t n);
		logic [ROW_W:0] m;
		begin
			m = ({{ROW_W{1'b0}}, 1'b1} << n) - 1'b1;
			low_mask = m[ROW_W-1:0];
		end
	endfunction

	// Index of lowest set bit; ROW_W if none.
	function automatic row_cnt_t first_set(input logic [ROW_W:0] v);
		row_cnt_t r;
		begin
			r = row_cnt_t'(ROW_W);
			for (int i = ROW_W; i >= 0; i--) begin
				if (v[i])
					r = row_cnt_t'(i);
			end
			first_set = r;
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dbrt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module dbrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/dirty_block_region_tracker.sv
// Dirty block region tracker: one dirty bit per 16x16 block, one RAM word per block column.
// A clear drops all valid bits; a mark reads and rewrites each covered column; mark all writes
// every grid column; an extract scans from the cursor for the next dirty block, takes its run of
// dirty rows, grows it right over columns holding the whole run and clears what it takes.
// One request at a time; a held result stalls the next. Reset: asynchronous, all blocks read
// clean via per-column valid bits, cursor zero. Needs dbrt_pkg, dbrt_ram, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dirty_block_region_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // rect_left, rect_top, rect_right, rect_bottom
	input  wire logic [1:0]  s_tuser,  // req_type
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // region_left, region_top, region_right, region_bottom
	output logic [1:0]       m_tuser   // region_valid, scan_done
);

	localparam int CW = dbrt_pkg::COL_CNT_W;
	localparam int RW = dbrt_pkg::ROW_CNT_W;
	localparam int IW = dbrt_pkg::COL_IDX_W;
	localparam int W  = dbrt_pkg::ROW_W;
	localparam int EW = dbrt_pkg::EDGE_W;

	dbrt_pkg::state_t state_q, state_nx;

	logic [EW-1:0]            vw_q, vh_q;
	logic [dbrt_pkg::MAX_BLOCK_COLS-1:0] valid_q;
	dbrt_pkg::col_cnt_t       col_q, rend_q, cur_col_q, l_q;
	dbrt_pkg::row_cnt_t       cur_row_q, t_q, b_q;
	dbrt_pkg::col_word_t      rmask_q, word_q, mk_q, seg_q;
	logic [W:0]               y_q;
	logic                     first_q, found_q;
	dbrt_pkg::req_t           kind_q;
	logic                     out_v_q;
	logic [47:0]              out_data_q;
	logic [1:0]               out_user_q;

	// grid size
	logic [EW:0] ncol_raw, nrow_raw;
	dbrt_pkg::col_cnt_t cols;
	dbrt_pkg::row_cnt_t rows;

	assign ncol_raw = ({1'b0, vw_q} + (EW+1)'(dbrt_pkg::BLOCK_WIDTH - 1)) >> dbrt_pkg::BLK_W_LG;
	assign nrow_raw = ({1'b0, vh_q} + (EW+1)'(dbrt_pkg::BLOCK_HEIGHT - 1)) >> dbrt_pkg::BLK_H_LG;
	assign cols = (ncol_raw > (EW+1)'(dbrt_pkg::MAX_BLOCK_COLS)) ?
		CW'(dbrt_pkg::MAX_BLOCK_COLS) : ncol_raw[CW-1:0];
	assign rows = (nrow_raw > (EW+1)'(dbrt_pkg::MAX_BLOCK_ROWS)) ?
		RW'(dbrt_pkg::MAX_BLOCK_ROWS) : nrow_raw[RW-1:0];

	// handshakes
	logic in_acc, cfg_wr, slot_free;
	assign pready    = 1'b1;
	assign s_tready  = (state_q == dbrt_pkg::ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign slot_free = !out_v_q || m_tready;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;
	assign prdata    = (dbrt_pkg::reg_idx_t'(paddr[2]) == dbrt_pkg::REG_VIEW_HEIGHT) ?
		32'(vh_q) : 32'(vw_q);

	// rectangle to block bounds, floor division by arithmetic shift
	logic signed [15:0] pl, pt, pr, pb, lb, tb;
	logic signed [16:0] pr_m1, pb_m1, rb, bb;
	logic [14:0]        cl, ct;
	logic [15:0]        cr, cb;
	logic               rect_empty;

	always_comb begin
		pl = $signed(s_tdata[15:0]);
		pt = $signed(s_tdata[31:16]);
		pr = $signed(s_tdata[47:32]);
		pb = $signed(s_tdata[63:48]);
		pr_m1 = {pr[15], pr} - 17'sd1;
		pb_m1 = {pb[15], pb} - 17'sd1;
		lb = pl >>> dbrt_pkg::BLK_W_LG;
		tb = pt >>> dbrt_pkg::BLK_H_LG;
		rb = (pr_m1 >>> dbrt_pkg::BLK_W_LG) + 17'sd1;
		bb = (pb_m1 >>> dbrt_pkg::BLK_H_LG) + 17'sd1;
		cl = lb[15] ? 15'd0 : lb[14:0];
		ct = tb[15] ? 15'd0 : tb[14:0];
		if (rb[16])
			cr = 16'd0;
		else if (rb[15:0] > 16'(cols))
			cr = 16'(cols);
		else
			cr = rb[15:0];
		if (bb[16])
			cb = 16'd0;
		else if (bb[15:0] > 16'(rows))
			cb = 16'(rows);
		else
			cb = bb[15:0];
		rect_empty = (pr <= pl) || (pb <= pt) || (16'(cl) >= cr) || (16'(ct) >= cb);
	end

	// memory
	logic                ram_we;
	dbrt_pkg::col_word_t ram_wdata, ram_rdata, rd_word;
	logic [IW-1:0]       col_idx;

	assign col_idx = col_q[IW-1:0];
	assign rd_word = ram_rdata & {W{valid_q[col_idx]}};

	dbrt_ram #(
		.WIDTH(W),
		.DEPTH(dbrt_pkg::MAX_BLOCK_COLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_idx),
		.wdata(ram_wdata),
		.raddr(col_idx),
		.rdata(ram_rdata)
	);

	// extract datapath
	dbrt_pkg::col_word_t first_mask, masked, seg, grow_hit;
	dbrt_pkg::row_cnt_t  b_new;

	assign first_mask = first_q ? dbrt_pkg::low_mask(cur_row_q) : '0;
	assign masked     = rd_word & ~first_mask;
	assign seg        = mk_q & ~y_q[W-1:0];
	assign b_new      = dbrt_pkg::first_set(y_q);
	assign grow_hit   = rd_word & seg_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dbrt_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (dbrt_pkg::req_t'(s_tuser))
						dbrt_pkg::REQ_MARK:    state_nx = rect_empty ? dbrt_pkg::ST_RESP :
							dbrt_pkg::ST_MRD;
						dbrt_pkg::REQ_CLEAR:   state_nx = dbrt_pkg::ST_RESP;
						dbrt_pkg::REQ_FILL:    state_nx = dbrt_pkg::ST_FILL;
						dbrt_pkg::REQ_EXTRACT: state_nx = dbrt_pkg::ST_XRD;
						default:               state_nx = dbrt_pkg::ST_RESP;
					endcase
				end
			end
			dbrt_pkg::ST_MRD:  state_nx = dbrt_pkg::ST_MWR;
			dbrt_pkg::ST_MWR:  state_nx = (col_q + 1'b1 == rend_q) ? dbrt_pkg::ST_RESP :
				dbrt_pkg::ST_MRD;
			dbrt_pkg::ST_FILL: state_nx = (col_q == cols) ? dbrt_pkg::ST_RESP : dbrt_pkg::ST_FILL;
			dbrt_pkg::ST_XRD:  state_nx = (col_q >= cols) ? dbrt_pkg::ST_RESP : dbrt_pkg::ST_XT;
			dbrt_pkg::ST_XT:   state_nx = (masked == '0) ? dbrt_pkg::ST_XRD : dbrt_pkg::ST_XSEG;
			dbrt_pkg::ST_XSEG: state_nx = dbrt_pkg::ST_XB;
			dbrt_pkg::ST_XB:   state_nx = dbrt_pkg::ST_RRD;
			dbrt_pkg::ST_RRD:  state_nx = (col_q == cols) ? dbrt_pkg::ST_RESP : dbrt_pkg::ST_RCHK;
			dbrt_pkg::ST_RCHK: state_nx = (grow_hit == seg_q) ? dbrt_pkg::ST_RRD :
				dbrt_pkg::ST_RESP;
			dbrt_pkg::ST_RESP: state_nx = slot_free ? dbrt_pkg::ST_IDLE : dbrt_pkg::ST_RESP;
			default:           state_nx = dbrt_pkg::ST_IDLE;
		endcase
	end

	// memory write controls
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = rd_word;
		case (state_q)
			dbrt_pkg::ST_MWR: begin
				ram_we    = 1'b1;
				ram_wdata = rd_word | rmask_q;
			end
			dbrt_pkg::ST_FILL: begin
				ram_we    = (col_q != cols);
				ram_wdata = rmask_q;
			end
			dbrt_pkg::ST_XB: begin
				ram_we    = 1'b1;
				ram_wdata = word_q & ~seg;
			end
			dbrt_pkg::ST_RCHK: begin
				ram_we    = (grow_hit == seg_q);
				ram_wdata = rd_word & ~seg_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dbrt_pkg::ST_IDLE;
			vw_q      <= EW'(640);
			vh_q      <= EW'(480);
			valid_q   <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ram_we)
				valid_q[col_idx] <= 1'b1;
			if (m_tready)
				out_v_q <= 1'b0;
			if (cfg_wr) begin
				if (dbrt_pkg::reg_idx_t'(paddr[2]) == dbrt_pkg::REG_VIEW_HEIGHT)
					vh_q <= pwdata[EW-1:0];
				else
					vw_q <= pwdata[EW-1:0];
				valid_q   <= '0;
				cur_col_q <= '0;
				cur_row_q <= '0;
			end
			if (in_acc && dbrt_pkg::req_t'(s_tuser) != dbrt_pkg::REQ_EXTRACT) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
				if (dbrt_pkg::req_t'(s_tuser) == dbrt_pkg::REQ_CLEAR)
					valid_q <= '0;
			end
			if (state_q == dbrt_pkg::ST_XRD && col_q >= cols) begin
				cur_col_q <= '0;
				cur_row_q <= '0;
			end
			if (state_q == dbrt_pkg::ST_XB) begin
				cur_col_q <= col_q;
				cur_row_q <= t_q;
			end
			if (state_q == dbrt_pkg::ST_RESP && slot_free)
				out_v_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q  <= dbrt_pkg::req_t'(s_tuser);
			found_q <= 1'b0;
			first_q <= 1'b1;
			case (dbrt_pkg::req_t'(s_tuser))
				dbrt_pkg::REQ_MARK: begin
					col_q   <= cl[CW-1:0];
					rend_q  <= cr[CW-1:0];
					rmask_q <= dbrt_pkg::low_mask(cb[RW-1:0]) & ~dbrt_pkg::low_mask(ct[RW-1:0]);
				end
				dbrt_pkg::REQ_FILL: begin
					col_q   <= '0;
					rmask_q <= dbrt_pkg::low_mask(rows);
				end
				default: begin
					col_q <= cur_col_q;
				end
			endcase
		end
		case (state_q)
			dbrt_pkg::ST_MWR, dbrt_pkg::ST_RRD: begin
				if (state_q == dbrt_pkg::ST_MWR)
					col_q <= col_q + 1'b1;
			end
			dbrt_pkg::ST_FILL: begin
				if (col_q != cols)
					col_q <= col_q + 1'b1;
			end
			dbrt_pkg::ST_XT: begin
				word_q <= rd_word;
				mk_q   <= masked;
				t_q    <= dbrt_pkg::first_set({1'b0, masked});
				if (masked == '0) begin
					col_q   <= col_q + 1'b1;
					first_q <= 1'b0;
				end
			end
			dbrt_pkg::ST_XSEG: begin
				y_q <= {1'b0, mk_q} + ({{W{1'b0}}, 1'b1} << t_q);
			end
			dbrt_pkg::ST_XB: begin
				seg_q   <= seg;
				b_q     <= b_new;
				l_q     <= col_q;
				found_q <= 1'b1;
				col_q   <= col_q + 1'b1;
			end
			dbrt_pkg::ST_RCHK: begin
				if (grow_hit == seg_q)
					col_q <= col_q + 1'b1;
			end
			default: ;
		endcase
		if (state_q == dbrt_pkg::ST_RESP && slot_free) begin
			out_data_q <= '0;
			out_user_q <= '0;
			if (kind_q == dbrt_pkg::REQ_EXTRACT) begin
				if (found_q) begin
					out_user_q       <= 2'b01;
					out_data_q[10:0] <= EW'(32'(l_q) << dbrt_pkg::BLK_W_LG);
					out_data_q[21:11] <= EW'(32'(t_q) << dbrt_pkg::BLK_H_LG);
					out_data_q[32:22] <= EW'(32'(col_q) << dbrt_pkg::BLK_W_LG);
					out_data_q[43:33] <= EW'(32'(b_q) << dbrt_pkg::BLK_H_LG);
				end else begin
					out_user_q <= 2'b10;
				end
			end
		end
	end

	`DBRT_ASSERT(a_flags_excl, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "region and done both set")
	`DBRT_ASSERT_NEXT(a_one_at_a_time, in_acc, !s_tready, "request taken while busy")
	`DBRT_ASSERT(a_write_states, ram_we |-> (state_q == dbrt_pkg::ST_MWR ||
		state_q == dbrt_pkg::ST_FILL || state_q == dbrt_pkg::ST_XB ||
		state_q == dbrt_pkg::ST_RCHK), "RAM written outside a write state")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench of dirty_block_region_tracker: directed and random requests over the stream port,
// view size changes over APB, results checked against a behavioural grid model. Needs dbrt_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	typedef struct packed {
		logic        valid;
		logic        done;
		logic [10:0] left, top, right, bottom;
	} region_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	dirty_block_region_tracker dut (.*);

	// model state
	bit      grid [64][64];	// [row][col]
	int      cursor;
	int      vw, vh;
	region_t region_q[$];
	int      errors;
	int      burst_left;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int n_cols();
		int n = (vw + 15) / 16;
		return n > 64 ? 64 : n;
	endfunction

	function automatic int n_rows();
		int n = (vh + 15) / 16;
		return n > 64 ? 64 : n;
	endfunction

	function automatic int fdiv16(int a);
		return a >>> 4;	// arithmetic shift is floor division
	endfunction

	function automatic void clear_grid();
		foreach (grid[y, x]) grid[y][x] = 0;
		cursor = 0;
	endfunction

	function automatic void fill(int l, int t, int r, int b, bit v);
		for (int y = t; y < b; y++)
			for (int x = l; x < r; x++)
				grid[y][x] = v;
	endfunction

	function automatic region_t predict_region(dbrt_pkg::req_t rq, logic signed [15:0] pl,
			logic signed [15:0] pt, logic signed [15:0] pr, logic signed [15:0] pb);
		region_t res;
		int cols, rows, l, t, r, b, idx, total;
		bit found, whole;
		res = '0;
		cols = n_cols();
		rows = n_rows();
		case (rq)
		dbrt_pkg::REQ_MARK: begin
			if (int'(pr) - int'(pl) > 0 && int'(pb) - int'(pt) > 0) begin
				l = fdiv16(pl);
				t = fdiv16(pt);
				r = fdiv16(int'(pr) - 1) + 1;
				b = fdiv16(int'(pb) - 1) + 1;
				if (l < 0) l = 0;
				if (t < 0) t = 0;
				if (r > cols) r = cols;
				if (b > rows) b = rows;
				if (l < r && t < b) fill(l, t, r, b, 1);
			end
			cursor = 0;
		end
		dbrt_pkg::REQ_CLEAR: clear_grid();
		dbrt_pkg::REQ_FILL: begin
			fill(0, 0, cols, rows, 1);
			cursor = 0;
		end
		default: begin
			total = cols * rows;
			found = 0;
			for (idx = cursor; idx < total; idx++) begin
				l = idx / rows;
				t = idx % rows;
				if (grid[t][l]) begin
					found = 1;
					break;
				end
			end
			if (!found) begin
				cursor = 0;
				res.done = 1;
				return res;
			end
			cursor = idx;
			grid[t][l] = 0;
			for (b = t + 1; b < rows; b++)
				if (!grid[b][l]) break;
			for (r = l + 1; r < cols; r++) begin
				whole = 1;
				for (int y = t; y < b; y++)
					if (!grid[y][r]) whole = 0;
				if (!whole) break;
			end
			fill(l, t, r, b, 0);
			res.valid  = 1;
			res.left   = 11'(l * 16);
			res.top    = 11'(t * 16);
			res.right  = 11'(r * 16);
			res.bottom = 11'(b * 16);
		end
		endcase
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		region_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tuser[1], m_tdata[10:0], m_tdata[21:11],
				m_tdata[32:22], m_tdata[43:33]};
			if (region_q.size() == 0) begin
				$display("%t: unexpected result, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = region_q.pop_front();
				if (got !== want || m_tdata[47:44] !== 4'd0) begin
					$display("%t: region mismatch, expected %h, actual %h",
						$time, want, got);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		int ph;
		ph = ($time / 12) % 97;
		if (ph < 30) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send_req(dbrt_pkg::req_t rq, logic [15:0] l = 0, logic [15:0] t = 0,
			logic [15:0] r = 0, logic [15:0] b = 0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		region_q.insert(region_q.size(), predict_region(rq, l, t, r, b));
		s_tvalid <= 1'b1;
		s_tuser  <= rq;
		s_tdata  <= {b, r, t, l};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		s_tvalid <= 1'b0;
		s_tdata  <= 64'($urandom()) << 32 | 64'($urandom());
		// the block is busy for at least this cycle after taking a request
		@(posedge clk);
	endtask

	task automatic drain();
		while (region_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(dbrt_pkg::reg_idx_t idx, int value);
		drain();
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 3'(idx) << 2; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == dbrt_pkg::REG_VIEW_WIDTH) vw = value & 11'h7ff;
		else vh = value & 11'h7ff;
		clear_grid();
		@(posedge clk);
	endtask

	function automatic logic [15:0] rnd_coord(int span);
		case ($urandom_range(0, 9))
		0: return 16'($urandom());
		1: return 16'(-$urandom_range(0, 40));
		default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	task automatic rand_reqs(int n);
		logic [15:0] l, t;
		int span;
		span = (vw > vh ? vw : vh) + 40;
		repeat (n) begin
			case ($urandom_range(0, 19))
			0: send_req(dbrt_pkg::REQ_CLEAR);
			1: send_req(dbrt_pkg::REQ_FILL);
			2, 3, 4, 5, 6, 7: begin
				l = rnd_coord(span);
				t = rnd_coord(span);
				if ($urandom_range(0, 7) == 0)
					send_req(dbrt_pkg::REQ_MARK, l, t, rnd_coord(span), rnd_coord(span));
				else
					send_req(dbrt_pkg::REQ_MARK, l, t, l + 16'($urandom_range(1, 200)),
						t + 16'($urandom_range(1, 200)));
			end
			default: send_req(dbrt_pkg::REQ_EXTRACT);
			endcase
		end
	endtask

	task automatic test_directed();
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_MARK, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_MARK, 100, 100, 100, 200);	// empty width
		send_req(dbrt_pkg::REQ_MARK, 100, 200, 150, 100);	// inverted height
		send_req(dbrt_pkg::REQ_MARK, -5, -20, 3, 1);	// partly above and left
		send_req(dbrt_pkg::REQ_MARK, 2000, 10, 3000, 40);	// off grid
		send_req(dbrt_pkg::REQ_MARK, 17, 33, 70, 50);
		send_req(dbrt_pkg::REQ_MARK, 40, 20, 41, 100);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_FILL);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_EXTRACT);
		send_req(dbrt_pkg::REQ_CLEAR);
		send_req(dbrt_pkg::REQ_EXTRACT);
	endtask

	task automatic test_view_sizes();
		int sizes[] = '{1, 16, 17, 1023, 1024, 0, 2047, 100, 33};
		foreach (sizes[i]) begin
			write_reg(dbrt_pkg::REG_VIEW_WIDTH, sizes[i]);
			write_reg(dbrt_pkg::REG_VIEW_HEIGHT, sizes[(i + 3) % sizes.size()]);
			send_req(dbrt_pkg::REQ_FILL);
			repeat (4) send_req(dbrt_pkg::REQ_EXTRACT);
			rand_reqs(40);
		end
	endtask

	task automatic test_random();
		write_reg(dbrt_pkg::REG_VIEW_WIDTH, 200);
		write_reg(dbrt_pkg::REG_VIEW_HEIGHT, 150);
		rand_reqs(500);
		drain();	// sender holds off until all results are back
		write_reg(dbrt_pkg::REG_VIEW_WIDTH, 640);
		write_reg(dbrt_pkg::REG_VIEW_HEIGHT, 480);
		rand_reqs(450);
	endtask

	initial begin
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		vw = 640; vh = 480; errors = 0; burst_left = 0;
		clear_grid();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_view_sizes();
		test_random();
		drain();
		if (errors == 0 && region_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
